>>> rtl/core/grwc_pkg.sv
// shared types, codes and constants of the grid ray wall caster
package grwc_pkg;

    // field widths
    localparam int POS_W  = 28;
    localparam int DIST_W = 29;

    // distance reported for no hit and on overflow
    localparam logic [DIST_W-1:0] DIST_MAX = 29'h1FFF_FFFF;

    // cordic constants
    localparam int CORDIC_N = 30;
    localparam logic [16:0] RAD_PER_UNIT = 17'd102944;
    localparam logic [29:0] ATAN_Q30 [0:CORDIC_N-1] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2
    };

    // item opcodes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_HCAST = 2'd1,
        OP_VCAST = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic [1:0] CFG_PLAYER_X = 2'd0;
    localparam logic [1:0] CFG_PLAYER_Y = 2'd1;
    localparam logic [1:0] CFG_MAP_COLS = 2'd2;
    localparam logic [1:0] CFG_MAP_ROWS = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic cell_wr;
        logic start;
        logic cordic_step;
        logic sel;
        logic m_init;
        logic prod;
        logic div_step;
        logic n_init;
        logic tile_ld;
        logic addr_ld;
        logic advance;
        logic hit_latch;
        logic sq;
        logic sum;
        logic sqrt_step;
        logic dist_latch;
        logic nohit;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic cordic_last;
        logic degenerate;
        logic div_last;
        logic oob;
        logic wall;
        logic k_last;
        logic sqrt_last;
    } t_sts;

endpackage

>>> rtl/core/grwc_ctrl.sv
// controller state machine sequencing clear, writes and ray casts
module grwc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    input  grwc_pkg::t_sts  i_sts,
    input  logic            i_out_free,
    output logic            o_in_ready,
    output grwc_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_CORDIC, ST_SEL, ST_TDA, ST_TDB, ST_MINIT, ST_PROD,
        ST_DIV, ST_NINIT, ST_BOUND, ST_TD1, ST_TD2, ST_ADDR, ST_READ, ST_TEST,
        ST_SQ, ST_SUM, ST_SQRT, ST_DIST, ST_NOHIT, ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (grwc_pkg::t_opcode'(i_opcode))
                        grwc_pkg::OP_WRITE: o_cmd.cell_wr = 1'b1;
                        grwc_pkg::OP_HCAST, grwc_pkg::OP_VCAST: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_CORDIC;
                        end
                        grwc_pkg::OP_NONE: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_last) n_state = ST_SEL;
            end
            ST_SEL: begin
                if (i_sts.degenerate) begin
                    n_state = ST_NOHIT;
                end else begin
                    o_cmd.sel = 1'b1;
                    n_state   = ST_TDA;
                end
            end
            ST_TDA: n_state = ST_TDB;
            ST_TDB: n_state = ST_MINIT;
            ST_MINIT: begin
                o_cmd.m_init = 1'b1;
                n_state      = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_NINIT;
            end
            ST_NINIT: begin
                o_cmd.n_init = 1'b1;
                n_state      = ST_BOUND;
            end
            ST_BOUND: begin
                if (i_sts.oob) begin
                    n_state = ST_NOHIT;
                end else begin
                    o_cmd.tile_ld = 1'b1;
                    n_state       = ST_TD1;
                end
            end
            ST_TD1: n_state = ST_TD2;
            ST_TD2: n_state = ST_ADDR;
            ST_ADDR: begin
                o_cmd.addr_ld = 1'b1;
                n_state       = ST_READ;
            end
            ST_READ: n_state = ST_TEST;
            ST_TEST: begin
                priority if (i_sts.wall) begin
                    o_cmd.hit_latch = 1'b1;
                    n_state         = ST_SQ;
                end else if (i_sts.k_last) begin
                    n_state = ST_NOHIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_BOUND;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) n_state = ST_DIST;
            end
            ST_DIST: begin
                o_cmd.dist_latch = 1'b1;
                n_state          = ST_OUT;
            end
            ST_NOHIT: begin
                o_cmd.nohit = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/grwc_dpath.sv
// datapath: wall map memory, cordic, division, tile march and square root
module grwc_dpath #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int TILE_SIZE = 64,
    parameter int MAX_STEPS = 1000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  grwc_pkg::t_cmd              i_cmd,
    output grwc_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic [5:0]                  i_cell_col,
    input  logic [5:0]                  i_cell_row,
    input  logic                        i_cell_is_wall,
    input  logic [15:0]                 i_ray_angle,
    input  logic [grwc_pkg::POS_W-1:0]  i_player_x,
    input  logic [grwc_pkg::POS_W-1:0]  i_player_y,
    input  logic [6:0]                  i_map_cols,
    input  logic [6:0]                  i_map_rows,
    output logic                        o_res_hit,
    output logic [grwc_pkg::POS_W-1:0]  o_res_x,
    output logic [grwc_pkg::POS_W-1:0]  o_res_y,
    output logic [grwc_pkg::DIST_W-1:0] o_res_dist
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_STEPS + 1);
    localparam logic [24:0] TQ    = 25'(TILE_SIZE * 65536);
    localparam logic [21:0] RECIP = 22'((1 << 24) / TILE_SIZE);

    // magnitude shift of a signed value, rounding toward zero
    function automatic logic signed [32:0] shr_tz(input logic signed [32:0] v,
                                                  input logic [4:0] s);
        logic [32:0] mag;
        mag = v[32] ? 33'(-v) : 33'(v);
        mag = mag >> s;
        return v[32] ? -$signed(mag) : $signed(mag);
    endfunction

    // first stage of division by tile size: reciprocal estimate
    function automatic logic [15:0] tile_est(input logic [15:0] v);
        logic [37:0] p;
        p = 38'(v) * 38'(RECIP);
        return 16'(p >> 24);
    endfunction

    // second stage: one correction step
    function automatic logic [15:0] tile_fix(input logic [15:0] v, input logic [15:0] q0);
        logic [24:0] rem;
        rem = 25'(v) - 25'(q0) * 25'(TILE_SIZE);
        return q0 + 16'(rem >= 25'(TILE_SIZE));
    endfunction

    // wall map memory
    logic            r_mem [DEPTH];
    logic            r_rd;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_clr_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_data;
    logic [31:0]     cell_lin;
    logic            cell_ok;

    // cordic
    logic                r_axis;
    logic                r_vert;
    logic [1:0]          r_quad;
    logic signed [32:0]  r_x;
    logic signed [32:0]  r_y;
    logic signed [32:0]  r_z;
    logic [4:0]          r_ci;
    logic signed [32:0]  xs;
    logic signed [32:0]  ys;
    logic [30:0]         prod_z;

    // setup
    logic                r_major_neg;
    logic                r_minor_neg;
    logic [30:0]         r_num;
    logic [30:0]         r_den;
    logic [32:0]         r_major_lim;
    logic [32:0]         r_minor_lim;
    logic [27:0]         r_major_p;
    logic [27:0]         r_minor_p;
    logic [8:0]          cols;
    logic [8:0]          rows;
    logic [32:0]         wlim;
    logic [32:0]         hlim;
    logic                neg_c;
    logic                neg_s;
    logic [30:0]         mc;
    logic [30:0]         ms;

    // tile divider
    logic [15:0]         r_tv_a;
    logic [15:0]         r_tv_b;
    logic [15:0]         r_tq0_a;
    logic [15:0]         r_tq0_b;
    logic [15:0]         r_tq_a;
    logic [15:0]         r_tq_b;

    // march
    logic signed [35:0]  r_m;
    logic signed [59:0]  r_n;
    logic [55:0]         r_stp;
    logic [KW-1:0]       r_k;
    logic [40:0]         m_base;
    logic signed [35:0]  pd;
    logic signed [35:0]  chk;
    logic [31:0]         col_c;
    logic [31:0]         row_c;
    logic [31:0]         addr_lin;

    // division
    logic [55:0]         r_da;
    logic [55:0]         r_db;
    logic [31:0]         r_rem_a;
    logic [31:0]         r_rem_b;
    logic [5:0]          r_dc;
    logic [31:0]         rs_a;
    logic [31:0]         rs_b;
    logic                ge_a;
    logic                ge_b;

    // distance
    logic [32:0]         r_hx;
    logic [32:0]         r_hy;
    logic                r_dok;
    logic [61:0]         r_sx;
    logic [61:0]         r_sy;
    logic [62:0]         r_sv;
    logic [63:0]         r_sres;
    logic [62:0]         r_sbit;
    logic [4:0]          r_sc;
    logic [32:0]         dx;
    logic [32:0]         dy;
    logic [63:0]         tsum;

    // memory write port selection
    always_comb begin
        cell_lin = 32'(i_cell_row) * 32'(MAX_COLS) + 32'(i_cell_col);
        cell_ok  = (9'(i_cell_col) < 9'(MAX_COLS)) && (9'(i_cell_row) < 9'(MAX_ROWS));
        wr_en    = i_cmd.clr_step || (i_cmd.cell_wr && cell_ok);
        wr_addr  = i_cmd.clr_step ? r_clr_addr : cell_lin[AW-1:0];
        wr_data  = i_cmd.clr_step ? 1'b0 : i_cell_is_wall;
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[r_addr];
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // combinational helpers
    always_comb begin
        xs     = shr_tz(r_x, r_ci);
        ys     = shr_tz(r_y, r_ci);
        prod_z = 31'(i_ray_angle[13:0]) * 31'(grwc_pkg::RAD_PER_UNIT);
        cols   = (9'(i_map_cols) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(i_map_cols);
        rows   = (9'(i_map_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(i_map_rows);
        wlim   = 33'(cols) * 33'(TQ);
        hlim   = 33'(rows) * 33'(TQ);
        neg_c  = (r_quad == 2'd1) || (r_quad == 2'd2);
        neg_s  = r_quad[1];
        mc     = r_quad[0] ? r_y[30:0] : r_x[30:0];
        ms     = r_quad[0] ? r_x[30:0] : r_y[30:0];
        m_base = 41'(r_tq_a) * 41'(TQ) + (r_major_neg ? 41'd0 : 41'(TQ));
        pd     = r_major_neg ? $signed({8'b0, r_major_p}) - r_m
                             : r_m - $signed({8'b0, r_major_p});
        chk    = r_major_neg ? r_m - 36'sd65536 : r_m;
        col_c  = r_vert ? chk[31:0] : r_n[31:0];
        row_c  = r_vert ? r_n[31:0] : chk[31:0];
        addr_lin = 32'(r_tq_b) * 32'(MAX_COLS) + 32'(r_tq_a);
        rs_a   = {r_rem_a[30:0], r_da[55]};
        rs_b   = {r_rem_b[30:0], r_db[55]};
        ge_a   = rs_a >= {1'b0, r_den};
        ge_b   = rs_b >= {1'b0, r_den};
        dx     = (r_hx >= 33'(i_player_x)) ? r_hx - 33'(i_player_x) : 33'(i_player_x) - r_hx;
        dy     = (r_hy >= 33'(i_player_y)) ? r_hy - 33'(i_player_y) : 33'(i_player_y) - r_hy;
        tsum   = r_sres + 64'(r_sbit);
    end

    // status
    always_comb begin
        o_sts.clr_last    = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.cordic_last = (r_ci == 5'(grwc_pkg::CORDIC_N - 1));
        o_sts.degenerate  = r_axis || r_x[32] || (r_x == 33'sd0) || r_y[32] || (r_y == 33'sd0);
        o_sts.div_last    = (r_dc == 6'd55);
        o_sts.oob         = chk[35] || (chk >= $signed({3'b0, r_major_lim})) ||
                            r_n[59] || (r_n >= $signed({27'b0, r_minor_lim}));
        o_sts.wall        = r_rd;
        o_sts.k_last      = (r_k == KW'(MAX_STEPS - 1));
        o_sts.sqrt_last   = (r_sc == 5'd31);
    end

    // cordic rotation
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_axis <= (i_ray_angle[13:0] == 14'd0);
            r_vert <= (grwc_pkg::t_opcode'(i_opcode) == grwc_pkg::OP_VCAST);
            r_quad <= i_ray_angle[15:14];
            r_x    <= 33'sd1 <<< 30;
            r_y    <= 33'sd0;
            r_z    <= $signed({2'b0, prod_z});
            r_ci   <= 5'd0;
        end else if (i_cmd.cordic_step) begin
            if (!r_z[32]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - $signed({3'b0, grwc_pkg::ATAN_Q30[r_ci]});
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + $signed({3'b0, grwc_pkg::ATAN_Q30[r_ci]});
            end
            r_ci <= r_ci + 5'd1;
        end
    end

    // axis selection and limits
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_major_neg <= r_vert ? neg_c : neg_s;
            r_minor_neg <= r_vert ? neg_s : neg_c;
            r_num       <= r_vert ? ms : mc;
            r_den       <= r_vert ? mc : ms;
            r_major_lim <= r_vert ? wlim : hlim;
            r_minor_lim <= r_vert ? hlim : wlim;
            r_major_p   <= r_vert ? i_player_x : i_player_y;
            r_minor_p   <= r_vert ? i_player_y : i_player_x;
        end
    end

    // division by tile size, two stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_tv_a <= 16'(r_vert ? i_player_x[27:16] : i_player_y[27:16]);
            r_tv_b <= 16'd0;
        end else if (i_cmd.tile_ld) begin
            r_tv_a <= col_c[31:16];
            r_tv_b <= row_c[31:16];
        end
        r_tq0_a <= tile_est(r_tv_a);
        r_tq0_b <= tile_est(r_tv_b);
        r_tq_a  <= tile_fix(r_tv_a, r_tq0_a);
        r_tq_b  <= tile_fix(r_tv_b, r_tq0_b);
    end

    // gridline march and memory address
    always_ff @(posedge i_clk) begin
        if (i_cmd.m_init) begin
            r_m <= $signed(m_base[35:0]);
        end else if (i_cmd.advance) begin
            r_m <= r_major_neg ? r_m - $signed({11'b0, TQ}) : r_m + $signed({11'b0, TQ});
        end
        if (i_cmd.n_init) begin
            r_n   <= r_minor_neg ? $signed({32'b0, r_minor_p}) - $signed({4'b0, r_da})
                                 : $signed({32'b0, r_minor_p}) + $signed({4'b0, r_da});
            r_stp <= r_db;
            r_k   <= '0;
        end else if (i_cmd.advance) begin
            r_n <= r_minor_neg ? r_n - $signed({4'b0, r_stp}) : r_n + $signed({4'b0, r_stp});
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.addr_ld) r_addr <= addr_lin[AW-1:0];
    end

    // restoring division of offset and step by the denominator
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_da    <= 56'(pd[24:0]) * 56'(r_num) + 56'(r_den >> 1);
            r_db    <= 56'(TQ) * 56'(r_num) + 56'(r_den >> 1);
            r_rem_a <= 32'd0;
            r_rem_b <= 32'd0;
            r_dc    <= 6'd0;
        end else if (i_cmd.div_step) begin
            r_rem_a <= ge_a ? rs_a - {1'b0, r_den} : rs_a;
            r_rem_b <= ge_b ? rs_b - {1'b0, r_den} : rs_b;
            r_da    <= {r_da[54:0], ge_a};
            r_db    <= {r_db[54:0], ge_b};
            r_dc    <= r_dc + 6'd1;
        end
    end

    // hit point, squares and bitwise square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_latch) begin
            r_hx <= r_vert ? r_m[32:0] : r_n[32:0];
            r_hy <= r_vert ? r_n[32:0] : r_m[32:0];
        end
        if (i_cmd.sq) begin
            r_dok <= (dx[32:31] == 2'b00) && (dy[32:31] == 2'b00);
            r_sx  <= 62'(dx[30:0]) * 62'(dx[30:0]);
            r_sy  <= 62'(dy[30:0]) * 62'(dy[30:0]);
        end
        if (i_cmd.sum) begin
            r_sv   <= 63'(r_sx) + 63'(r_sy);
            r_sres <= 64'd0;
            r_sbit <= 63'd1 << 62;
            r_sc   <= 5'd0;
        end else if (i_cmd.sqrt_step) begin
            if ({1'b0, r_sv} >= tsum) begin
                r_sv   <= 63'({1'b0, r_sv} - tsum);
                r_sres <= (r_sres >> 1) + 64'(r_sbit);
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
            r_sc   <= r_sc + 5'd1;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.nohit) begin
            o_res_hit  <= 1'b0;
            o_res_x    <= '0;
            o_res_y    <= '0;
            o_res_dist <= grwc_pkg::DIST_MAX;
        end else if (i_cmd.dist_latch) begin
            o_res_hit  <= 1'b1;
            o_res_x    <= r_hx[27:0];
            o_res_y    <= r_hy[27:0];
            o_res_dist <= (!r_dok || (r_sres > 64'(grwc_pkg::DIST_MAX))) ?
                          grwc_pkg::DIST_MAX : r_sres[28:0];
        end
    end

endmodule

>>> rtl/core/grid_ray_wall_caster_unit.sv
// top level of the grid ray wall caster: config registers, output register, core
//
// channel   direction  signals
// in        input      i_in_valid / o_in_ready, opcode, cell and angle fields
// out       output     o_out_valid / i_out_ready, hit, hit point, distance
// cfg       input      i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// a cell write or an unused opcode is handled in the idle state
// a cast runs setup (30 cordic steps, a 56-step divider of offset and step together),
// then the march one tile step at a time, then the square root on a hit
// after reset a clearing pass over all MAX_ROWS*MAX_COLS cells runs with in ready low
// one word at a time; the next word is taken while a result waits in the output register
module grid_ray_wall_caster_unit #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int TILE_SIZE = 64,
    parameter int MAX_STEPS = 1000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [5:0]                  i_cell_col,
    input  logic [5:0]                  i_cell_row,
    input  logic                        i_cell_is_wall,
    input  logic [15:0]                 i_ray_angle,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic [grwc_pkg::POS_W-1:0]  o_hit_x,
    output logic [grwc_pkg::POS_W-1:0]  o_hit_y,
    output logic [grwc_pkg::DIST_W-1:0] o_distance,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [27:0]                 i_cfg_data
);

    logic [grwc_pkg::POS_W-1:0]  r_player_x;
    logic [grwc_pkg::POS_W-1:0]  r_player_y;
    logic [6:0]                  r_map_cols;
    logic [6:0]                  r_map_rows;
    logic                        r_out_valid;
    logic                        r_hit;
    logic [grwc_pkg::POS_W-1:0]  r_hit_x;
    logic [grwc_pkg::POS_W-1:0]  r_hit_y;
    logic [grwc_pkg::DIST_W-1:0] r_distance;
    grwc_pkg::t_cmd              cmd;
    grwc_pkg::t_sts              sts;
    logic                        out_free;
    logic                        res_hit;
    logic [grwc_pkg::POS_W-1:0]  res_x;
    logic [grwc_pkg::POS_W-1:0]  res_y;
    logic [grwc_pkg::DIST_W-1:0] res_dist;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
            r_map_cols <= 7'd64;
            r_map_rows <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                grwc_pkg::CFG_PLAYER_X: r_player_x <= i_cfg_data;
                grwc_pkg::CFG_PLAYER_Y: r_player_y <= i_cfg_data;
                grwc_pkg::CFG_MAP_COLS: r_map_cols <= i_cfg_data[6:0];
                grwc_pkg::CFG_MAP_ROWS: r_map_rows <= i_cfg_data[6:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (cmd.out_load) begin
            r_hit      <= res_hit;
            r_hit_x    <= res_x;
            r_hit_y    <= res_y;
            r_distance <= res_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_x     = r_hit_x;
    assign o_hit_y     = r_hit_y;
    assign o_distance  = r_distance;

    // controller
    grwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath
    grwc_dpath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .TILE_SIZE (TILE_SIZE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_is_wall (i_cell_is_wall),
        .i_ray_angle    (i_ray_angle),
        .i_player_x     (r_player_x),
        .i_player_y     (r_player_y),
        .i_map_cols     (r_map_cols),
        .i_map_rows     (r_map_rows),
        .o_res_hit      (res_hit),
        .o_res_x        (res_x),
        .o_res_y        (res_y),
        .o_res_dist     (res_dist)
    );

endmodule

>>> rtl/core/grwc_checker.sv
// port-level checker of the grid ray wall caster and its bind
module grwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_opcode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_hit,
    input logic [27:0] o_hit_x,
    input logic [27:0] o_hit_y,
    input logic [28:0] o_distance
);

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit) &&
        $stable(o_hit_x) && $stable(o_hit_y) && $stable(o_distance))
        else $error("result word changed while stalled");

    // reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not held off after reset");

    // a miss reports zero point and maximum distance
    a_miss_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_hit_x == 28'd0 && o_hit_y == 28'd0 &&
        o_distance == 29'h1FFF_FFFF)
        else $error("miss word malformed");

    // a write or unused word makes no result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == 2'd0 || i_opcode == 2'd3) &&
        !o_out_valid |=> !o_out_valid)
        else $error("result from a word that makes none");

endmodule

bind grid_ray_wall_caster_unit grwc_checker u_grwc_checker (.*);
